// ----- src/rcfd_pkg.sv -----
// shared types, constants and codes of the rc channel frame decoder
`default_nettype none

package rcfd_pkg;

	// frame store
	localparam int BUFFER_BYTES_DEF = 64;
	localparam int ADDR_MAX_W       = 8;

	// frame codes
	localparam logic [7:0] SYNC_CODE = 8'hC8;
	localparam logic [7:0] RC_TYPE   = 8'h16;
	localparam logic [7:0] MIN_LEN   = 8'd24;

	// store positions swept after the twelfth byte: type byte, then channel bytes
	localparam int SWEEP_FIRST = 2;
	localparam int SWEEP_LAST  = 11;
	localparam int SWEEP_BYTES = SWEEP_LAST - SWEEP_FIRST + 1;
	localparam int SWEEP_PTR_W = 4;
	localparam int CHAN_BYTES  = SWEEP_BYTES - 1;

	// channel scaling
	localparam int          CH_W     = 11;
	localparam logic [11:0] CH_MID   = 12'd992;
	localparam logic [10:0] THR_LOW  = 11'd172;
	localparam logic [10:0] SW_LEVEL = 11'd1200;

	// thrust = trunc((ch2 - 172) * 256000 / 1639), by reciprocal multiply
	localparam int THR_SCALE    = 256000;
	localparam int THR_DIV      = 1639;
	localparam int THR_SHIFT    = 24;
	localparam int THR_RECIP_W  = 32;
	localparam int THR_Q_W      = 19;
	localparam int THR_PROD_W   = CH_W + THR_RECIP_W;
	localparam longint unsigned THR_RECIP_L =
		((longint'(THR_SCALE) << THR_SHIFT) + longint'(THR_DIV) - 1) / longint'(THR_DIV);
	localparam logic [THR_RECIP_W-1:0] THR_RECIP = THR_RECIP_W'(THR_RECIP_L);

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [31:0] now_tick;
	} rcfd_in_t;

	typedef struct packed {
		logic signed [11:0] roll_half;
		logic signed [11:0] pitch_half;
		logic signed [11:0] yaw_half;
		logic signed [19:0] thrust_q8;
		logic               armed;
		logic               mode_switch;
		logic [31:0]        stamp;
	} rcfd_out_t;

	// write request into the frame store, plus the start of the read sweep
	typedef struct packed {
		logic                  wr_en;
		logic [ADDR_MAX_W-1:0] wr_addr;
		logic [7:0]            wr_data;
		logic                  sweep_go;
	} rcfd_wr_t;

	// decoded channel values of the frame in progress
	typedef struct packed {
		logic signed [11:0] roll_half;
		logic signed [11:0] pitch_half;
		logic signed [11:0] yaw_half;
		logic signed [19:0] thrust_q8;
		logic               armed;
		logic               mode_switch;
		logic               type_ok;
	} rcfd_chan_t;

endpackage

`default_nettype wire

// ----- src/rcfd_if.sv -----
// request channels of the decoder: received bytes in, decoded frames out
`default_nettype none

interface rcfd_in_if
	import rcfd_pkg::*;
();
	logic     valid;
	logic     ready;
	rcfd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rcfd_out_if
	import rcfd_pkg::*;
();
	logic      valid;
	logic      ready;
	rcfd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/rc_channel_frame_decoder.sv -----
// top level of the rc channel frame decoder
`default_nettype none

// Takes one received byte per cycle on bytes and emits one request on frames for
// each good rc channels frame: sync 0xC8, length L of at least 24, type 0x16 and an
// 8-bit sum of bytes 2..L that equals the final byte. A frame ends once L+2 bytes,
// but at least three, are held; a frame that fills BUFFER_BYTES positions without
// ending is dropped and the hunt for sync restarts. Bytes are accepted back to
// back, one per cycle, whenever the skid stage behind the output register is empty,
// so a result waiting to be taken does not hold up the byte stream. The result is
// registered in the output register, or in the skid stage while that is held, and
// carries the now_tick of its final byte as stamp. Every byte from the sync on is
// written into a single frame store memory at its position; once the twelfth byte
// of a frame is in, a sweep reads positions 2 to 11 through the memory's registered
// read port and a two-stage pipeline decodes the channels and the thrust, so
// everything is ready before the earliest final byte of a long enough frame,
// fourteen bytes later. The store needs no clearing pass after reset, as only
// positions written for the current frame are ever read. Channels 0, 1 and 3 come
// out minus 992; thrust is (channel 2 - 172) * 1000 / 1639 in Q8, truncated toward
// zero; channels 4 and 5 above 1200 set armed and mode_switch.
module rc_channel_frame_decoder
	import rcfd_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rcfd_in_if.sink     bytes,
	rcfd_out_if.source  frames
);

	// byte request handshake
	logic accept;
	logic full;

	// framer to store: write request and sweep start
	rcfd_wr_t wr;
	logic     frame_ok;

	// swept bytes and their decoded values
	logic [SWEEP_BYTES-1:0][7:0] frame_bytes;
	rcfd_chan_t                  chan;

	// result request into the output stages
	logic      push;
	rcfd_out_t push_data;

	assign bytes.ready = !full;
	assign accept      = bytes.valid && bytes.ready;

	rcfd_framer #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_framer (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (bytes.data.rx_byte),
		.wr       (wr),
		.frame_ok (frame_ok)
	);

	rcfd_store #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr          (wr),
		.frame_bytes (frame_bytes)
	);

	rcfd_unpack u_unpack (
		.clk         (clk),
		.frame_bytes (frame_bytes),
		.chan        (chan)
	);

	// type check joins length and checksum on the final byte
	always_comb begin
		push                  = frame_ok && chan.type_ok;
		push_data.roll_half   = chan.roll_half;
		push_data.pitch_half  = chan.pitch_half;
		push_data.yaw_half    = chan.yaw_half;
		push_data.thrust_q8   = chan.thrust_q8;
		push_data.armed       = chan.armed;
		push_data.mode_switch = chan.mode_switch;
		push_data.stamp       = bytes.data.now_tick;
	end

	rcfd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.frames    (frames)
	);

endmodule

`default_nettype wire

// ----- src/rcfd_framer.sv -----
// byte framing: sync hunt, length, running checksum and completion
`default_nettype none

module rcfd_framer
	import rcfd_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output rcfd_wr_t   wr,
	output logic       frame_ok
);

	localparam int CNT_W = $clog2(BUFFER_BYTES);

	logic [CNT_W-1:0] count_q;
	logic [7:0]       len_q;
	logic [7:0]       sum_q;

	logic       hunting;
	logic       is_sync;
	logic [8:0] pos9;
	logic [8:0] len_p1;
	logic       is_last;
	logic       is_full;

	always_comb begin
		hunting = (count_q == '0);
		is_sync = (rx_byte == SYNC_CODE);
		pos9    = 9'(count_q);
		len_p1  = {1'b0, len_q} + 9'd1;
		// the length byte itself never completes a frame
		is_last = !hunting && (pos9 >= 9'd2) && (pos9 >= len_p1);
		is_full = (pos9 + 9'd1) == 9'(BUFFER_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			len_q   <= '0;
			sum_q   <= '0;
		end else if (accept) begin
			if (hunting) begin
				if (is_sync) begin
					count_q <= CNT_W'(1);
					sum_q   <= '0;
				end
			end else if (is_last) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				count_q <= is_full ? '0 : count_q + CNT_W'(1);
				if (pos9 == 9'd1) begin
					len_q <= rx_byte;
				end
				if (is_full) begin
					sum_q <= '0;
				end else if (pos9 >= 9'd2) begin
					sum_q <= sum_q + rx_byte;
				end
			end
		end
	end

	always_comb begin
		wr.wr_en    = accept && (!hunting || is_sync);
		wr.wr_addr  = ADDR_MAX_W'(count_q);
		wr.wr_data  = rx_byte;
		wr.sweep_go = accept && !hunting && (count_q == CNT_W'(SWEEP_LAST));
		frame_ok    = accept && is_last && (len_q >= MIN_LEN) && (sum_q == rx_byte);
	end

endmodule

`default_nettype wire

// ----- src/rcfd_store.sv -----
// frame store memory with the read sweep that collects type and channel bytes
`default_nettype none

module rcfd_store
	import rcfd_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rcfd_wr_t                         wr,
	output logic [SWEEP_BYTES-1:0][7:0]      frame_bytes
);

	localparam int ADDR_W = $clog2(BUFFER_BYTES);

	logic [7:0] mem_q [BUFFER_BYTES];
	logic [7:0] rd_data_q;

	logic [SWEEP_PTR_W-1:0] sweep_ptr_q;
	logic                   sweep_act_q;
	logic                   cap_v_q;
	logic [SWEEP_PTR_W-1:0] cap_idx_q;
	logic [SWEEP_BYTES-1:0][7:0] bytes_q;

	logic [ADDR_W-1:0] rd_addr;

	assign rd_addr = {{(ADDR_W - SWEEP_PTR_W){1'b0}}, sweep_ptr_q};

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem_q[wr.wr_addr[ADDR_W-1:0]] <= wr.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_act_q) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// sweep reads one position a cycle, from the type byte to the last channel byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_ptr_q <= '0;
			sweep_act_q <= 1'b0;
			cap_v_q     <= 1'b0;
			cap_idx_q   <= '0;
		end else begin
			if (wr.sweep_go) begin
				sweep_ptr_q <= SWEEP_PTR_W'(SWEEP_FIRST);
				sweep_act_q <= 1'b1;
			end else if (sweep_act_q) begin
				sweep_ptr_q <= sweep_ptr_q + SWEEP_PTR_W'(1);
				if (sweep_ptr_q == SWEEP_PTR_W'(SWEEP_LAST)) begin
					sweep_act_q <= 1'b0;
				end
			end
			cap_v_q   <= sweep_act_q;
			cap_idx_q <= sweep_ptr_q - SWEEP_PTR_W'(SWEEP_FIRST);
		end
	end

	always_ff @(posedge clk) begin
		if (cap_v_q) begin
			bytes_q[cap_idx_q] <= rd_data_q;
		end
	end

	assign frame_bytes = bytes_q;

endmodule

`default_nettype wire

// ----- src/rcfd_unpack.sv -----
// channel unpacking, offset removal, switch levels and thrust scaling
`default_nettype none

module rcfd_unpack
	import rcfd_pkg::*;
(
	input  logic                        clk,
	input  logic [SWEEP_BYTES-1:0][7:0] frame_bytes,
	output rcfd_chan_t                  chan
);

	logic [8*CHAN_BYTES-1:0] pl;
	logic [CH_W-1:0]         c0, c1, c2, c3, c4, c5;

	logic signed [11:0] roll_s1, pitch_s1, yaw_s1;
	logic               armed_s1, mode_s1, type_s1, neg_s1;
	logic [CH_W-1:0]    mag_s1;

	logic signed [11:0]    roll_s2, pitch_s2, yaw_s2;
	logic                  armed_s2, mode_s2, type_s2, neg_s2;
	logic [THR_PROD_W-1:0] prod_s2;

	logic [THR_Q_W-1:0] thr_mag;
	logic [19:0]        thr_ext;

	always_comb begin
		// payload starts at the first channel byte, little-endian bit order
		pl = frame_bytes[SWEEP_BYTES-1:1];
		c0 = pl[0*CH_W +: CH_W];
		c1 = pl[1*CH_W +: CH_W];
		c2 = pl[2*CH_W +: CH_W];
		c3 = pl[3*CH_W +: CH_W];
		c4 = pl[4*CH_W +: CH_W];
		c5 = pl[5*CH_W +: CH_W];
	end

	always_ff @(posedge clk) begin
		roll_s1  <= $signed(12'(c0) - CH_MID);
		pitch_s1 <= $signed(12'(c1) - CH_MID);
		yaw_s1   <= $signed(12'(c3) - CH_MID);
		armed_s1 <= (c4 > SW_LEVEL);
		mode_s1  <= (c5 > SW_LEVEL);
		type_s1  <= (frame_bytes[0] == RC_TYPE);
		neg_s1   <= (c2 < THR_LOW);
		mag_s1   <= (c2 < THR_LOW) ? (THR_LOW - c2) : (c2 - THR_LOW);
	end

	always_ff @(posedge clk) begin
		roll_s2  <= roll_s1;
		pitch_s2 <= pitch_s1;
		yaw_s2   <= yaw_s1;
		armed_s2 <= armed_s1;
		mode_s2  <= mode_s1;
		type_s2  <= type_s1;
		neg_s2   <= neg_s1;
		prod_s2  <= THR_PROD_W'(mag_s1) * THR_PROD_W'(THR_RECIP);
	end

	// magnitude path gives truncation toward zero for negative thrust
	always_comb begin
		thr_mag = prod_s2[THR_SHIFT +: THR_Q_W];
		thr_ext = 20'(thr_mag);
		chan.roll_half   = roll_s2;
		chan.pitch_half  = pitch_s2;
		chan.yaw_half    = yaw_s2;
		chan.thrust_q8   = $signed(neg_s2 ? (~thr_ext + 20'd1) : thr_ext);
		chan.armed       = armed_s2;
		chan.mode_switch = mode_s2;
		chan.type_ok     = type_s2;
	end

endmodule

`default_nettype wire

// ----- src/rcfd_outbuf.sv -----
// output register with a skid stage for decoded frames
`default_nettype none

module rcfd_outbuf
	import rcfd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rcfd_out_t          push_data,
	output logic               full,
	rcfd_out_if.source         frames
);

	logic      out_v_q;
	logic      skid_v_q;
	rcfd_out_t out_q;
	rcfd_out_t skid_q;
	logic      pop;

	assign pop = out_v_q && frames.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_v_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign full         = skid_v_q;
	assign frames.valid = out_v_q;
	assign frames.data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a frame while output register is empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("frame pushed while both stages are occupied");

	a_stall_lands_in_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_v_q && !frames.ready && !skid_v_q) |=> (skid_v_q && out_v_q))
		else $error("stalled frame was not kept in the skid stage");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench of the rc channel frame decoder: frames of bytes in, decoded channels out
`default_nettype none

module tb_top;
	import rcfd_pkg::*;

	localparam int BUF_BYTES   = BUFFER_BYTES_DEF;
	localparam int CLK_HALF    = 10;
	localparam int RESET_CYC   = 8;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_BYTES = 330;
	localparam int TAIL_CYCLES = 20;
	localparam int NUM_CHANS   = 16;

	// what a stimulus row sends
	typedef enum {FK_FRAME, FK_BAD_TYPE, FK_BAD_SUM, FK_NOISE, FK_JUNK} frame_kind_t;
	// where the expected frame of a row comes from
	typedef enum {CHK_MODEL, CHK_NONE, CHK_FIXED} chk_t;

	typedef struct {
		frame_kind_t kind;
		int          len;     // length byte, or byte count for noise and junk
		int          fill;    // value of every channel, negative for random channels
		logic [31:0] tick;
		chk_t        chk;
		rcfd_out_t   want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	rcfd_in_if  in_ch ();
	rcfd_out_if out_ch ();

	rc_channel_frame_decoder #(
		.BUFFER_BYTES(BUF_BYTES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (in_ch),
		.frames (out_ch)
	);

	// directed frames: extremes, switch and thrust thresholds, every way a frame is dropped
	stim_row_t dir_rows [17] = '{
		'{FK_NOISE,    5,   0,    32'h0000_0000, CHK_MODEL, '0},
		'{FK_FRAME,    24,  2047, 32'hFFFF_FFFF, CHK_FIXED,
			'{12'sd1055, 12'sd1055, 12'sd1055, 20'sd292861, 1'b1, 1'b1, 32'hFFFF_FFFF}},
		'{FK_FRAME,    24,  0,    32'h0000_0000, CHK_FIXED,
			'{-12'sd992, -12'sd992, -12'sd992, -20'sd26865, 1'b0, 1'b0, 32'h0000_0000}},
		'{FK_FRAME,    24,  992,  32'h5A5A_5A5A, CHK_MODEL, '0},
		'{FK_FRAME,    24,  1200, 32'hA5A5_A5A5, CHK_MODEL, '0},
		'{FK_FRAME,    24,  1201, 32'h0F0F_0F0F, CHK_MODEL, '0},
		'{FK_FRAME,    24,  172,  32'hF0F0_F0F0, CHK_MODEL, '0},
		'{FK_BAD_TYPE, 24,  -1,   32'h1234_5678, CHK_NONE,  '0},
		'{FK_BAD_SUM,  24,  -1,   32'h8765_4321, CHK_NONE,  '0},
		'{FK_FRAME,    0,   -1,   32'h0000_0001, CHK_NONE,  '0},
		'{FK_FRAME,    1,   -1,   32'h0000_0002, CHK_NONE,  '0},
		'{FK_FRAME,    23,  -1,   32'h0000_0003, CHK_NONE,  '0},
		'{FK_FRAME,    62,  -1,   32'h8000_0000, CHK_MODEL, '0},
		'{FK_FRAME,    63,  -1,   32'h0000_0004, CHK_NONE,  '0},
		'{FK_FRAME,    255, -1,   32'h0000_0005, CHK_NONE,  '0},
		'{FK_FRAME,    25,  -1,   32'h7FFF_FFFF, CHK_MODEL, '0},
		'{FK_FRAME,    40,  -1,   32'hDEAD_BEEF, CHK_MODEL, '0}
	};

	// decoder state as predicted
	int          held;
	int          flen;
	logic [7:0]  fsum;
	logic [7:0]  rx_store [BUF_BYTES];

	rcfd_out_t   expected_frames [$];

	int errors       = 0;
	int frames_seen  = 0;
	int frames_sent  = 0;
	int bytes_sent   = 0;
	int phase_bytes  = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int quiet        = 0;

	// 11-bit little-endian channel out of the payload, which starts at store position 3
	function automatic logic [10:0] channel_at(input int idx);
		int          bitpos;
		int          base;
		logic [23:0] win;
		bitpos = idx * CH_W;
		base   = 3 + bitpos / 8;
		win    = {rx_store[base + 2], rx_store[base + 1], rx_store[base]};
		return 11'(win >> (bitpos % 8));
	endfunction

	// one accepted byte through the predicted decoder; returns 1 when a frame is decoded
	function automatic bit decode_byte(input logic [7:0] b, input logic [31:0] tick,
			output rcfd_out_t res);
		int          pos;
		bit          good;
		logic [10:0] c [6];
		res = '0;
		pos = held;
		if (pos == 0) begin
			// hunting: anything but sync is dropped
			if (b == SYNC_CODE) begin
				rx_store[0] = b;
				held        = 1;
				fsum        = '0;
			end
			return 1'b0;
		end
		if (pos >= BUF_BYTES) begin
			held = 0;
			return 1'b0;
		end
		rx_store[pos] = b;
		held          = pos + 1;
		if (pos == 1)
			flen = int'(b);
		if (held >= 3 && held >= flen + 2) begin
			good = flen >= int'(MIN_LEN) && rx_store[2] == RC_TYPE && fsum == b;
			held = 0;
			fsum = '0;
			if (!good)
				return 1'b0;
			for (int i = 0; i < 6; i++)
				c[i] = channel_at(i);
			res.roll_half   = 12'(int'(c[0]) - int'(CH_MID));
			res.pitch_half  = 12'(int'(c[1]) - int'(CH_MID));
			res.yaw_half    = 12'(int'(c[3]) - int'(CH_MID));
			res.thrust_q8   = 20'((int'(c[2]) - int'(THR_LOW)) * THR_SCALE / THR_DIV);
			res.armed       = c[4] > SW_LEVEL;
			res.mode_switch = c[5] > SW_LEVEL;
			res.stamp       = tick;
			return 1'b1;
		end
		if (pos >= 2)
			fsum = fsum + b;
		// frame too long for the store: back to hunting
		if (held >= BUF_BYTES) begin
			held = 0;
			fsum = '0;
		end
		return 1'b0;
	endfunction

	// channel values, weighted towards the decode thresholds
	function automatic logic [10:0] pick_channel();
		case ($urandom_range(39))
			0:       return 11'd0;
			1:       return 11'd2047;
			2:       return 11'd171;
			3:       return 11'd172;
			4:       return 11'd173;
			5:       return 11'd991;
			6:       return 11'd992;
			7:       return 11'd993;
			8:       return 11'd1200;
			9:       return 11'd1201;
			default: return 11'($urandom);
		endcase
	endfunction

	// one byte request, with a random gap in front; predicted once accepted
	task automatic send_byte(input logic [7:0] b, input logic [31:0] tick, input chk_t chk,
			input rcfd_out_t want);
		rcfd_out_t res;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= '{rx_byte: b, now_tick: tick};
		do
			@(posedge clk);
		while (!in_ch.ready);
		if (decode_byte(b, tick, res)) begin
			if (chk == CHK_MODEL)
				expected_frames.push_back(res);
			else if (chk == CHK_FIXED)
				expected_frames.push_back(want);
		end
	endtask

	task automatic send_frame(input frame_kind_t kind, input int len, input int fill,
			input bit fixed_tick, input logic [31:0] tick, input chk_t chk,
			input rcfd_out_t want);
		logic [7:0]   fb [$];
		logic [175:0] packed_ch;
		logic [7:0]   s;
		int           n;
		if (kind == FK_NOISE || kind == FK_JUNK) begin
			// junk may hold a stray sync that swallows what follows
			for (int i = 0; i < len; i++) begin
				s = 8'($urandom);
				if (kind == FK_NOISE && s == SYNC_CODE)
					s = ~s;
				fb.push_back(s);
			end
		end else begin
			// lengths of 0 and 1 still take three bytes; overlong frames stop at the store size
			n = (len + 2 < 3) ? 3 : ((len + 2 > BUF_BYTES) ? BUF_BYTES : len + 2);
			for (int i = 0; i < n; i++)
				fb.push_back(8'($urandom));
			fb[0] = SYNC_CODE;
			fb[1] = 8'(len);
			fb[2] = RC_TYPE;
			if (kind == FK_BAD_TYPE) begin
				do
					s = 8'($urandom);
				while (s == RC_TYPE);
				fb[2] = s;
			end
			for (int k = 0; k < NUM_CHANS; k++)
				packed_ch[k * CH_W +: CH_W] = (fill < 0) ? pick_channel() : 11'(fill);
			for (int j = 0; j < 22; j++)
				if (3 + j < n)
					fb[3 + j] = packed_ch[j * 8 +: 8];
			// final byte: sum of type and payload, unless length is below 2 or overflows the store
			if (len >= 2 && len + 2 <= BUF_BYTES) begin
				s = '0;
				for (int i = 2; i <= len; i++)
					s = s + fb[i];
				if (kind == FK_BAD_SUM)
					s = s + 8'd1;
				fb[len + 1] = s;
			end
			frames_sent++;
			bytes_sent  += fb.size();
			phase_bytes += fb.size();
		end
		foreach (fb[i])
			send_byte(fb[i], fixed_tick ? tick : 32'($urandom), chk, want);
	endtask

	// mostly good frames with random content, the rest broken or noise
	task automatic random_frame();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			send_frame(FK_FRAME, ($urandom_range(99) < 85) ? 24 : $urandom_range(62, 25),
				-1, 1'b0, '0, CHK_MODEL, '0);
		else if (r < 78)
			send_frame(FK_BAD_SUM, $urandom_range(30, 24), -1, 1'b0, '0, CHK_MODEL, '0);
		else if (r < 84)
			send_frame(FK_BAD_TYPE, $urandom_range(30, 24), -1, 1'b0, '0, CHK_MODEL, '0);
		else if (r < 90)
			send_frame(FK_FRAME, $urandom_range(23, 0), -1, 1'b0, '0, CHK_MODEL, '0);
		else if (r < 94)
			send_frame(FK_FRAME, $urandom_range(255, 63), -1, 1'b0, '0, CHK_MODEL, '0);
		else if (r < 98)
			send_frame(FK_NOISE, $urandom_range(8, 1), -1, 1'b0, '0, CHK_MODEL, '0);
		else
			send_frame(FK_JUNK, $urandom_range(6, 1), -1, 1'b0, '0, CHK_MODEL, '0);
	endtask

	// hold the byte stream until every expected frame has come out
	task automatic wait_frames_out();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_frames.size() != 0);
	endtask

	task automatic match_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// receiver: stalls at random by the current profile
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// every decoded frame request against the oldest expectation
	always @(posedge clk) begin
		rcfd_out_t got;
		rcfd_out_t want;
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_frames.size() == 0) begin
				$display("%0t: frame expected none, got %p", $time, got);
				errors++;
			end else begin
				want = expected_frames.pop_front();
				frames_seen++;
				match_field("roll_half", want.roll_half, got.roll_half);
				match_field("pitch_half", want.pitch_half, got.pitch_half);
				match_field("yaw_half", want.yaw_half, got.yaw_half);
				match_field("thrust_q8", want.thrust_q8, got.thrust_q8);
				match_field("armed", want.armed, got.armed);
				match_field("mode_switch", want.mode_switch, got.mode_switch);
				match_field("stamp", want.stamp, got.stamp);
			end
		end
	end

	// watchdog: too long without any request moving on either side
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, quiet);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.data   <= '0;
		held         = 0;
		flen         = 0;
		fsum         = '0;
		foreach (rx_store[i])
			rx_store[i] = '0;

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, sender sparse gaps and receiver stalling half the time
		snd_idle_pct = 12;
		rcv_idle_pct = 51;
		foreach (dir_rows[i])
			send_frame(dir_rows[i].kind, dir_rows[i].len, dir_rows[i].fill, 1'b1,
				dir_rows[i].tick, dir_rows[i].chk, dir_rows[i].want);
		wait_frames_out();

		// random frames over three idling profiles, draining between them
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle_pct = (ph == 0) ? 12 : ((ph == 1) ? 51 : 0);
			rcv_idle_pct = (ph == 0) ? 51 : ((ph == 1) ? 12 : 0);
			phase_bytes  = 0;
			while (phase_bytes < PHASE_BYTES)
				random_frame();
			wait_frames_out();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d frames in %0d bytes: good, short, overlong, bad type, bad sum",
			frames_sent, bytes_sent);
		$display("checked %0d decoded frames field by field, %0d mismatches",
			frames_seen, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
